// ----- design/assert_macros.svh -----
// Assertion macros for the backoff controller RTL.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with explicit clock and active-low reset.
`define SDB_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion on the block's clk_i and rst_ni.
`define SDB_ASSERT(label, prop, msg) \
  `SDB_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ----- design/sdb_pkg.sv -----
// Package of the semi-deterministic backoff controller: widths, codes, types,
// the microcode table and the entry-point decode. Depends on nothing.
`default_nettype none

package sdb_pkg;

  localparam int CW_W        = 10;
  localparam int FAIL_W      = 4;
  localparam int Q_W         = 16;
  localparam int SLOT_W      = 20;
  localparam int PSI_W       = 4;
  localparam int KIND_W      = 3;
  localparam int PC_W        = 5;
  localparam int APB_AW      = 5;
  localparam int APB_DW      = 32;
  localparam int REG_IDX_W   = 3;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;
  localparam int MUL_A_W     = 17;
  localparam int MUL_B_W     = 16;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int DET_W       = 25;

  localparam logic [KIND_W-1:0] KIND_ACK       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MISS_ACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MISS_CTS  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_COLLISION = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NOACK_END = 3'd4;

  localparam logic [REG_IDX_W-1:0] REG_CW_MIN = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CW_MAX = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PSI    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PHI    = 3'd4;

  localparam logic [CW_W-1:0]  CW_MIN_RST = 10'd15;
  localparam logic [CW_W-1:0]  CW_MAX_RST = 10'd1023;
  localparam logic [Q_W-1:0]   ALPHA_RST  = 16'd52429;
  localparam logic [PSI_W-1:0] PSI_RST    = 4'd6;
  localparam logic [Q_W-1:0]   PHI_RST    = 16'd64395;

  localparam logic [SLOT_W-1:0] SLOT_MAX = 20'hFFFFF;
  localparam logic [FAIL_W-1:0] FAIL_MAX = 4'd15;
  localparam logic [Q_W-1:0]    Q_FULL   = 16'hFFFF;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_RESET_WIN,
    OP_MUL_A,
    OP_MAC_B,
    OP_LOAD_RATIO,
    OP_SUCC_SLOT,
    OP_CLR_RATIO,
    OP_SLOT,
    OP_FAIL_UPD,
    OP_POW_INIT,
    OP_POW_STEP,
    OP_POW_DONE,
    OP_DET_SLOT
  } sdb_op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_PSI_LE1,
    COND_CNT_GT1,
    COND_RATIO_GT
  } sdb_cond_e;

  typedef struct packed {
    sdb_op_e         op;
    sdb_cond_e       cond;
    logic [PC_W-1:0] target;
    logic            last;
  } sdb_uword_t;

  typedef struct packed {
    logic [CW_W-1:0]  cw_min;
    logic [CW_W-1:0]  cw_max;
    logic [Q_W-1:0]   alpha;
    logic [PSI_W-1:0] psi;
    logic [Q_W-1:0]   phi;
  } sdb_cfg_t;

  typedef struct packed {
    logic psi_le1;
    logic cnt_gt1;
    logic ratio_gt;
  } sdb_flags_t;

  typedef struct packed {
    logic              backoff_valid;
    logic [SLOT_W-1:0] backoff_slots;
    logic              deterministic;
    logic [CW_W-1:0]   window_now;
    logic [FAIL_W-1:0] failures_now;
    logic [Q_W-1:0]    ratio_now;
  } sdb_res_t;

  // program addresses
  localparam logic [PC_W-1:0] PC_NONE     = 5'd0;
  localparam logic [PC_W-1:0] PC_ACK      = 5'd1;
  localparam logic [PC_W-1:0] PC_DROP     = 5'd6;
  localparam logic [PC_W-1:0] PC_SLOT     = 5'd8;
  localparam logic [PC_W-1:0] PC_CTS      = 5'd9;
  localparam logic [PC_W-1:0] PC_MISS_ACK = 5'd10;
  localparam logic [PC_W-1:0] PC_POW_STEP = 5'd12;
  localparam logic [PC_W-1:0] PC_POW_DONE = 5'd13;
  localparam logic [PC_W-1:0] PC_DET      = 5'd16;
  localparam logic [PC_W-1:0] PC_NOACK    = 5'd17;
  localparam logic [PC_W-1:0] PC_LAST     = 5'd17;

  function automatic sdb_uword_t mk(sdb_op_e op, sdb_cond_e cond,
                                    logic [PC_W-1:0] target, logic last);
    sdb_uword_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    w.last   = last;
    return w;
  endfunction

  function automatic sdb_uword_t rom_word(logic [PC_W-1:0] pc);
    sdb_uword_t w;
    unique case (pc)
      5'd0:    w = mk(OP_NOP,        COND_NEVER,    PC_NONE,     1'b1);
      5'd1:    w = mk(OP_RESET_WIN,  COND_NEVER,    PC_NONE,     1'b0);
      5'd2:    w = mk(OP_MUL_A,      COND_NEVER,    PC_NONE,     1'b0);
      5'd3:    w = mk(OP_MAC_B,      COND_NEVER,    PC_NONE,     1'b0);
      5'd4:    w = mk(OP_LOAD_RATIO, COND_NEVER,    PC_NONE,     1'b0);
      5'd5:    w = mk(OP_SUCC_SLOT,  COND_NEVER,    PC_NONE,     1'b1);
      5'd6:    w = mk(OP_RESET_WIN,  COND_NEVER,    PC_NONE,     1'b0);
      5'd7:    w = mk(OP_CLR_RATIO,  COND_NEVER,    PC_NONE,     1'b0);
      5'd8:    w = mk(OP_SLOT,       COND_NEVER,    PC_NONE,     1'b1);
      5'd9:    w = mk(OP_FAIL_UPD,   COND_ALWAYS,   PC_SLOT,     1'b0);
      5'd10:   w = mk(OP_FAIL_UPD,   COND_NEVER,    PC_NONE,     1'b0);
      5'd11:   w = mk(OP_POW_INIT,   COND_PSI_LE1,  PC_POW_DONE, 1'b0);
      5'd12:   w = mk(OP_POW_STEP,   COND_CNT_GT1,  PC_POW_STEP, 1'b0);
      5'd13:   w = mk(OP_POW_DONE,   COND_NEVER,    PC_NONE,     1'b0);
      5'd14:   w = mk(OP_NOP,        COND_RATIO_GT, PC_DET,      1'b0);
      5'd15:   w = mk(OP_CLR_RATIO,  COND_ALWAYS,   PC_SLOT,     1'b0);
      5'd16:   w = mk(OP_DET_SLOT,   COND_NEVER,    PC_NONE,     1'b1);
      5'd17:   w = mk(OP_RESET_WIN,  COND_ALWAYS,   PC_SLOT,     1'b0);
      default: w = mk(OP_NOP,        COND_NEVER,    PC_NONE,     1'b1);
    endcase
    return w;
  endfunction

  function automatic logic [PC_W-1:0] entry_pc(logic [KIND_W-1:0] kind,
                                               logic retry, logic last);
    logic [PC_W-1:0] pc;
    unique case (kind)
      KIND_ACK:       pc = last ? PC_ACK : PC_NONE;
      KIND_MISS_ACK:  pc = retry ? PC_MISS_ACK : PC_DROP;
      KIND_MISS_CTS:  pc = retry ? PC_CTS : PC_DROP;
      KIND_COLLISION: pc = PC_SLOT;
      KIND_NOACK_END: pc = PC_NOACK;
      default:        pc = PC_NONE;
    endcase
    return pc;
  endfunction

endpackage

`default_nettype wire

// ----- design/sdb_seq.sv -----
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on sdb_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sdb_seq (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start_i,
  input  wire  [sdb_pkg::PC_W-1:0]    entry_i,
  input  sdb_pkg::sdb_flags_t         flags_i,
  input  wire                         out_free_i,
  output sdb_pkg::sdb_op_e            op_o,
  output logic                        busy_o,
  output logic                        load_o
);

  logic                     busy_q, busy_d;
  logic                     fin_q, fin_d;
  logic [sdb_pkg::PC_W-1:0] pc_q, pc_d;
  sdb_pkg::sdb_uword_t      word;
  logic                     take;
  logic                     run;

  assign word = sdb_pkg::rom_word(pc_q);
  assign run  = busy_q && !fin_q;

  always_comb begin
    unique case (word.cond)
      sdb_pkg::COND_NEVER:    take = 1'b0;
      sdb_pkg::COND_ALWAYS:   take = 1'b1;
      sdb_pkg::COND_PSI_LE1:  take = flags_i.psi_le1;
      sdb_pkg::COND_CNT_GT1:  take = flags_i.cnt_gt1;
      sdb_pkg::COND_RATIO_GT: take = flags_i.ratio_gt;
      default:                take = 1'b0;
    endcase
  end

  assign load_o = fin_q && out_free_i;
  assign busy_o = busy_q;
  assign op_o   = run ? word.op : sdb_pkg::OP_NOP;

  always_comb begin
    busy_d = busy_q;
    fin_d  = fin_q;
    pc_d   = pc_q;
    if (start_i) begin
      busy_d = 1'b1;
      pc_d   = entry_i;
    end else if (run) begin
      if (word.last) begin
        fin_d = 1'b1;
      end else begin
        pc_d = take ? word.target : sdb_pkg::PC_W'(pc_q + 1'b1);
      end
    end else if (load_o) begin
      busy_d = 1'b0;
      fin_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      pc_q   <= sdb_pkg::PC_NONE;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      pc_q   <= pc_d;
    end
  end

  `SDB_ASSERT(a_fin_busy, fin_q |-> busy_q, "finish flag without active program")
  `SDB_ASSERT(a_start_idle, start_i |-> !busy_q, "start while a program runs")
  `SDB_ASSERT(a_pc_range, busy_q |-> (pc_q <= sdb_pkg::PC_LAST), "step counter off program")
  `SDB_ASSERT(a_load_idle, load_o |=> !busy_q, "sequencer still busy after handover")

endmodule

`default_nettype wire

// ----- design/sdb_dp.sv -----
// Datapath: backoff state, one shared 17x16 multiplier, accumulator, power loop
// registers and result registers, driven by the sequencer's op. Depends on sdb_pkg.
`default_nettype none

module sdb_dp (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  sdb_pkg::sdb_cfg_t            cfg_i,
  input  wire                          start_i,
  input  wire  [sdb_pkg::Q_W-1:0]      rand_slot_i,
  input  wire  [sdb_pkg::Q_W-1:0]      rand_fraction_i,
  input  sdb_pkg::sdb_op_e             op_i,
  output sdb_pkg::sdb_flags_t          flags_o,
  output sdb_pkg::sdb_res_t            res_o
);

  logic [sdb_pkg::CW_W-1:0]    window_q, window_d;
  logic [sdb_pkg::FAIL_W-1:0]  fail_q, fail_d;
  logic [sdb_pkg::Q_W-1:0]     ratio_q, ratio_d;
  logic [31:0]                 acc_q, acc_d;
  logic [sdb_pkg::Q_W-1:0]     pw_q, pw_d;
  logic [sdb_pkg::PSI_W-1:0]   cnt_q, cnt_d;
  logic [sdb_pkg::Q_W-1:0]     rslot_q, rslot_d;
  logic [sdb_pkg::Q_W-1:0]     rfrac_q, rfrac_d;
  logic                        valid_q, valid_d;
  logic                        det_q, det_d;
  logic [sdb_pkg::SLOT_W-1:0]  slots_q, slots_d;

  logic [sdb_pkg::MUL_A_W-1:0] mul_a;
  logic [sdb_pkg::MUL_B_W-1:0] mul_b;
  logic [sdb_pkg::PROD_W-1:0]  prod;
  logic [sdb_pkg::PROD_W-1:0]  mac_sum;
  logic [sdb_pkg::PROD_W-1:0]  rnd_prod;
  logic [sdb_pkg::CW_W:0]      win_dbl;
  logic [sdb_pkg::CW_W-1:0]    base;
  logic [sdb_pkg::DET_W-1:0]   det_shift;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op_i)
      sdb_pkg::OP_MUL_A: begin
        mul_a = 17'h10000 - {1'b0, cfg_i.alpha};
        mul_b = ratio_q;
      end
      sdb_pkg::OP_MAC_B: begin
        mul_a = {1'b0, cfg_i.alpha};
        mul_b = cfg_i.phi;
      end
      sdb_pkg::OP_POW_STEP: begin
        mul_a = {1'b0, pw_q};
        mul_b = ratio_q;
      end
      sdb_pkg::OP_SLOT: begin
        mul_a = sdb_pkg::MUL_A_W'({1'b0, window_q} + 11'd1);
        mul_b = rslot_q;
      end
      default: begin
      end
    endcase
  end

  assign prod      = mul_a * mul_b;
  assign mac_sum   = {1'b0, acc_q} + prod + 33'd32768;
  assign rnd_prod  = prod + 33'd32768;
  assign win_dbl   = {window_q, 1'b1};
  assign base      = sdb_pkg::CW_W'(({1'b0, cfg_i.cw_min} + 11'd1) >> 1);
  assign det_shift = sdb_pkg::DET_W'(base) << fail_q;

  always_comb begin
    window_d = window_q;
    fail_d   = fail_q;
    ratio_d  = ratio_q;
    acc_d    = acc_q;
    pw_d     = pw_q;
    cnt_d    = cnt_q;
    rslot_d  = rslot_q;
    rfrac_d  = rfrac_q;
    valid_d  = valid_q;
    det_d    = det_q;
    slots_d  = slots_q;
    if (start_i) begin
      rslot_d = rand_slot_i;
      rfrac_d = rand_fraction_i;
      valid_d = 1'b0;
      det_d   = 1'b0;
      slots_d = '0;
    end else begin
      unique case (op_i)
        sdb_pkg::OP_RESET_WIN: begin
          window_d = cfg_i.cw_min;
          fail_d   = '0;
        end
        sdb_pkg::OP_MUL_A:      acc_d   = prod[31:0];
        sdb_pkg::OP_MAC_B:      acc_d   = mac_sum[31:0];
        sdb_pkg::OP_LOAD_RATIO: ratio_d = acc_q[31:16];
        sdb_pkg::OP_SUCC_SLOT: begin
          valid_d = 1'b1;
          det_d   = 1'b1;
          slots_d = sdb_pkg::SLOT_W'(base);
        end
        sdb_pkg::OP_CLR_RATIO:  ratio_d = '0;
        sdb_pkg::OP_SLOT: begin
          valid_d = 1'b1;
          slots_d = sdb_pkg::SLOT_W'(prod[25:16]);
        end
        sdb_pkg::OP_FAIL_UPD: begin
          if (fail_q != sdb_pkg::FAIL_MAX) begin
            fail_d = fail_q + 1'b1;
          end
          window_d = (win_dbl < {1'b0, cfg_i.cw_max}) ? win_dbl[sdb_pkg::CW_W-1:0]
                                                      : cfg_i.cw_max;
        end
        sdb_pkg::OP_POW_INIT: begin
          pw_d  = ratio_q;
          cnt_d = cfg_i.psi - 1'b1;
        end
        sdb_pkg::OP_POW_STEP: begin
          pw_d  = rnd_prod[31:16];
          cnt_d = cnt_q - 1'b1;
        end
        sdb_pkg::OP_POW_DONE: begin
          ratio_d = (cfg_i.psi == '0) ? sdb_pkg::Q_FULL : pw_q;
        end
        sdb_pkg::OP_DET_SLOT: begin
          valid_d = 1'b1;
          det_d   = 1'b1;
          slots_d = (det_shift > sdb_pkg::DET_W'(sdb_pkg::SLOT_MAX)) ?
                    sdb_pkg::SLOT_MAX : det_shift[sdb_pkg::SLOT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= sdb_pkg::CW_MIN_RST;
      fail_q   <= '0;
      ratio_q  <= '0;
    end else begin
      window_q <= window_d;
      fail_q   <= fail_d;
      ratio_q  <= ratio_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    pw_q    <= pw_d;
    cnt_q   <= cnt_d;
    rslot_q <= rslot_d;
    rfrac_q <= rfrac_d;
    valid_q <= valid_d;
    det_q   <= det_d;
    slots_q <= slots_d;
  end

  assign flags_o.psi_le1  = cfg_i.psi <= 4'd1;
  assign flags_o.cnt_gt1  = cnt_q > 4'd1;
  assign flags_o.ratio_gt = ratio_q > rfrac_q;

  assign res_o.backoff_valid = valid_q;
  assign res_o.backoff_slots = slots_q;
  assign res_o.deterministic = det_q;
  assign res_o.window_now    = window_q;
  assign res_o.failures_now  = fail_q;
  assign res_o.ratio_now     = ratio_q;

endmodule

`default_nettype wire

// ----- design/semi_deterministic_backoff_top.sv -----
// Backoff controller for a Wi-Fi MAC, one event in and one result out per item.
// Each event runs the microcode program at its entry point: one for a success, one
// for an ignored event, one for a collision, one each for a retried CTS loss and a
// no-ack end, one for a dropped frame and one for a retried missed ack, in which the
// power loop reuses the single 17x16 multiplier once per exponent step. A result
// still waiting in the output register holds the sequencer until it can move. The
// next event is taken as soon as the result has moved to the output register.
// Top level: config registers, stream ports, output register;
// depends on sdb_pkg, sdb_seq and sdb_dp.
`default_nettype none

module semi_deterministic_backoff_top (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // APB configuration port
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [sdb_pkg::APB_AW-1:0]          paddr,
  input  wire  [sdb_pkg::APB_DW-1:0]          pwdata,
  output logic [sdb_pkg::APB_DW-1:0]          prdata,
  output logic                                pready,
  // event stream
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: retry_allowed, rand_slot[15:0], rand_fraction[15:0], zero fill
  input  wire  [sdb_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // tuser: kind[2:0]
  input  wire  [sdb_pkg::KIND_W-1:0]          s_axis_tuser,
  // tlast: last_fragment
  input  wire                                 s_axis_tlast,
  // result stream
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  // tdata: backoff_valid, backoff_slots[19:0], window_now[9:0],
  //        failures_now[3:0], ratio_now[15:0], zero fill
  output logic [sdb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // tuser: deterministic
  output logic                                m_axis_tuser
);

  sdb_pkg::sdb_cfg_t                 cfg_q, cfg_d;
  logic [sdb_pkg::REG_IDX_W-1:0]     reg_idx;
  logic                              cfg_wr;

  logic                              busy;
  logic                              load;
  logic                              start;
  logic                              out_free;
  sdb_pkg::sdb_op_e                  op;
  sdb_pkg::sdb_flags_t               flags;
  sdb_pkg::sdb_res_t                 res;

  logic                              out_valid_q, out_valid_d;
  logic [sdb_pkg::OUT_TDATA_W-1:0]   out_data_q, out_data_d;
  logic                              out_user_q, out_user_d;

  assign pready  = 1'b1;
  assign reg_idx = paddr[sdb_pkg::APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        sdb_pkg::REG_CW_MIN: cfg_d.cw_min = pwdata[sdb_pkg::CW_W-1:0];
        sdb_pkg::REG_CW_MAX: cfg_d.cw_max = pwdata[sdb_pkg::CW_W-1:0];
        sdb_pkg::REG_ALPHA:  cfg_d.alpha  = pwdata[sdb_pkg::Q_W-1:0];
        sdb_pkg::REG_PSI:    cfg_d.psi    = pwdata[sdb_pkg::PSI_W-1:0];
        sdb_pkg::REG_PHI:    cfg_d.phi    = pwdata[sdb_pkg::Q_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sdb_pkg::REG_CW_MIN: prdata = sdb_pkg::APB_DW'(cfg_q.cw_min);
      sdb_pkg::REG_CW_MAX: prdata = sdb_pkg::APB_DW'(cfg_q.cw_max);
      sdb_pkg::REG_ALPHA:  prdata = sdb_pkg::APB_DW'(cfg_q.alpha);
      sdb_pkg::REG_PSI:    prdata = sdb_pkg::APB_DW'(cfg_q.psi);
      sdb_pkg::REG_PHI:    prdata = sdb_pkg::APB_DW'(cfg_q.phi);
      default:             prdata = '0;
    endcase
  end

  assign s_axis_tready = !busy;
  assign start         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  sdb_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .entry_i    (sdb_pkg::entry_pc(s_axis_tuser, s_axis_tdata[0], s_axis_tlast)),
    .flags_i    (flags),
    .out_free_i (out_free),
    .op_o       (op),
    .busy_o     (busy),
    .load_o     (load)
  );

  sdb_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .start_i         (start),
    .rand_slot_i     (s_axis_tdata[16:1]),
    .rand_fraction_i (s_axis_tdata[32:17]),
    .op_i            (op),
    .flags_o         (flags),
    .res_o           (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_data_d  = {5'b0, res.ratio_now, res.failures_now, res.window_now,
                     res.backoff_slots, res.backoff_valid};
      out_user_d  = res.deterministic;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cw_min <= sdb_pkg::CW_MIN_RST;
      cfg_q.cw_max <= sdb_pkg::CW_MAX_RST;
      cfg_q.alpha  <= sdb_pkg::ALPHA_RST;
      cfg_q.psi    <= sdb_pkg::PSI_RST;
      cfg_q.phi    <= sdb_pkg::PHI_RST;
      out_valid_q  <= 1'b0;
    end else begin
      cfg_q        <= cfg_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for semi_deterministic_backoff_top: directed event table,
// then random event runs under several register settings, each result checked
// against the table or an in-bench predictor. Depends on sdb_pkg and the RTL only.

module tb_top;
  import sdb_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 160;
  localparam int PHASES      = 8;

  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              retry;
    logic              last_frag;
    logic [Q_W-1:0]    rslot;
    logic [Q_W-1:0]    rfrac;
  } bo_event_t;

  typedef struct packed {
    bo_event_t ev;
    logic [3:0] reps;
    logic       typed;
    sdb_res_t   want;
  } plan_row_t;

  typedef enum {RUN_ACK, RUN_FAIL, RUN_NOISE} run_kind_e;

  localparam sdb_res_t AT_REST = '{1'b0, 20'd0, 1'b0, 10'd15, 4'd0, 16'd0};
  localparam sdb_res_t NO_WANT = '0;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_AW-1:0]      paddr;
  logic [APB_DW-1:0]      pwdata;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // tdata: retry_allowed, rand_slot[15:0], rand_fraction[15:0], zero fill
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  // tuser: kind[2:0]
  logic [KIND_W-1:0]      s_axis_tuser;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // tdata: backoff_valid, backoff_slots[19:0], window_now[9:0],
  //        failures_now[3:0], ratio_now[15:0], zero fill
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // tuser: deterministic
  logic                   m_axis_tuser;

  sdb_cfg_t          cfg_q;
  logic [CW_W-1:0]   win_q;
  logic [FAIL_W-1:0] fails_q;
  logic [Q_W-1:0]    ratio_q;

  sdb_res_t    expected_backoffs[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned work_items;
  int unsigned quiet_cycles;
  int unsigned stall_left;
  bit          idle_on;

  plan_row_t directed_plan [0:20] = '{
    '{'{KIND_SPARE_A,   1'b0, 1'b0, 16'h0000, 16'h0000}, 4'd1, 1'b1, AT_REST},
    '{'{KIND_SPARE_C,   1'b1, 1'b1, 16'hFFFF, 16'hFFFF}, 4'd1, 1'b1, AT_REST},
    '{'{KIND_COLLISION, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF}, 4'd1, 1'b1,
      '{1'b1, 20'd15, 1'b0, 10'd15, 4'd0, 16'd0}},
    '{'{KIND_COLLISION, 1'b0, 1'b0, 16'h0000, 16'h0000}, 4'd1, 1'b1,
      '{1'b1, 20'd0, 1'b0, 10'd15, 4'd0, 16'd0}},
    '{'{KIND_ACK,       1'b1, 1'b0, 16'hFFFF, 16'hFFFF}, 4'd1, 1'b1, AT_REST},
    '{'{KIND_NOACK_END, 1'b0, 1'b1, 16'h8000, 16'h0000}, 4'd1, 1'b1,
      '{1'b1, 20'd8, 1'b0, 10'd15, 4'd0, 16'd0}},
    '{'{KIND_MISS_CTS,  1'b1, 1'b0, 16'hFFFF, 16'h0000}, 4'd1, 1'b1,
      '{1'b1, 20'd31, 1'b0, 10'd31, 4'd1, 16'd0}},
    '{'{KIND_MISS_ACK,  1'b1, 1'b0, 16'h0000, 16'h0000}, 4'd1, 1'b1,
      '{1'b1, 20'd0, 1'b0, 10'd63, 4'd2, 16'd0}},
    '{'{KIND_MISS_ACK,  1'b0, 1'b1, 16'hFFFF, 16'hFFFF}, 4'd1, 1'b1,
      '{1'b1, 20'd15, 1'b0, 10'd15, 4'd0, 16'd0}},
    '{'{KIND_MISS_CTS,  1'b0, 1'b0, 16'h0000, 16'hFFFF}, 4'd1, 1'b1,
      '{1'b1, 20'd0, 1'b0, 10'd15, 4'd0, 16'd0}},
    '{'{KIND_ACK,       1'b0, 1'b1, 16'h1234, 16'h5678}, 4'd3, 1'b0, NO_WANT},
    '{'{KIND_MISS_ACK,  1'b1, 1'b0, 16'hFFFF, 16'h0000}, 4'd1, 1'b0, NO_WANT},
    '{'{KIND_MISS_ACK,  1'b1, 1'b0, 16'h8000, 16'hFFFF}, 4'd1, 1'b0, NO_WANT},
    '{'{KIND_ACK,       1'b1, 1'b1, 16'h0000, 16'h0000}, 4'd2, 1'b0, NO_WANT},
    '{'{KIND_MISS_CTS,  1'b1, 1'b0, 16'hFFFF, 16'h0000}, 4'd6, 1'b0, NO_WANT},
    '{'{KIND_MISS_ACK,  1'b1, 1'b1, 16'hFFFF, 16'h0000}, 4'd1, 1'b0, NO_WANT},
    '{'{KIND_COLLISION, 1'b0, 1'b0, 16'hFFFF, 16'h0000}, 4'd1, 1'b0, NO_WANT},
    '{'{KIND_NOACK_END, 1'b1, 1'b0, 16'hABCD, 16'h0000}, 4'd1, 1'b0, NO_WANT},
    '{'{KIND_ACK,       1'b1, 1'b0, 16'hFFFF, 16'hFFFF}, 4'd1, 1'b0, NO_WANT},
    '{'{KIND_MISS_ACK,  1'b0, 1'b0, 16'hFFFF, 16'hFFFF}, 4'd1, 1'b0, NO_WANT},
    '{'{KIND_SPARE_B,   1'b1, 1'b0, 16'h5555, 16'hAAAA}, 4'd1, 1'b1, AT_REST}
  };

  semi_deterministic_backoff_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic logic [SLOT_W-1:0] slot_draw(logic [Q_W-1:0] rnd, logic [CW_W-1:0] cw);
    logic [31:0] prod;
    prod = 32'(rnd) * (32'(cw) + 32'd1);
    return SLOT_W'(prod >> 16);
  endfunction

  function automatic sdb_res_t predict_backoff(bo_event_t ev);
    sdb_res_t    r;
    logic [63:0] avg;
    logic [31:0] grown;
    logic [31:0] pw;
    logic [31:0] det_slots;
    int          i;
    r = '0;
    case (ev.kind)
      KIND_ACK: begin
        if (ev.last_frag) begin
          win_q   = cfg_q.cw_min;
          fails_q = '0;
          avg = (64'd65536 - 64'(cfg_q.alpha)) * 64'(ratio_q)
              + 64'(cfg_q.alpha) * 64'(cfg_q.phi) + 64'd32768;
          ratio_q = avg[31:16];
          r.backoff_valid = 1'b1;
          r.deterministic = 1'b1;
          r.backoff_slots = SLOT_W'((32'(cfg_q.cw_min) + 32'd1) >> 1);
        end
      end
      KIND_MISS_ACK, KIND_MISS_CTS: begin
        r.backoff_valid = 1'b1;
        if (!ev.retry) begin
          win_q   = cfg_q.cw_min;
          fails_q = '0;
          ratio_q = '0;
          r.backoff_slots = slot_draw(ev.rslot, win_q);
        end else begin
          grown = 32'd2 * (32'(win_q) + 32'd1) - 32'd1;
          if (fails_q != FAIL_MAX) fails_q = fails_q + 1'b1;
          win_q = (grown < 32'(cfg_q.cw_max)) ? grown[CW_W-1:0] : cfg_q.cw_max;
          if (ev.kind == KIND_MISS_ACK) begin
            if (cfg_q.psi == '0) begin
              pw = 32'(Q_FULL);
            end else begin
              pw = 32'(ratio_q);
              for (i = 1; i < int'(cfg_q.psi); i++) pw = (pw * 32'(ratio_q) + 32'd32768) >> 16;
            end
            ratio_q = pw[Q_W-1:0];
            if (ratio_q > ev.rfrac) begin
              det_slots = ((32'(cfg_q.cw_min) + 32'd1) >> 1) << fails_q;
              r.backoff_slots = (det_slots > 32'(SLOT_MAX)) ? SLOT_MAX : det_slots[SLOT_W-1:0];
              r.deterministic = 1'b1;
            end else begin
              ratio_q = '0;
              r.backoff_slots = slot_draw(ev.rslot, win_q);
            end
          end else begin
            r.backoff_slots = slot_draw(ev.rslot, win_q);
          end
        end
      end
      KIND_COLLISION: begin
        r.backoff_valid = 1'b1;
        r.backoff_slots = slot_draw(ev.rslot, win_q);
      end
      KIND_NOACK_END: begin
        r.backoff_valid = 1'b1;
        win_q   = cfg_q.cw_min;
        fails_q = '0;
        r.backoff_slots = slot_draw(ev.rslot, win_q);
      end
      default: ;
    endcase
    r.window_now   = win_q;
    r.failures_now = fails_q;
    r.ratio_now    = ratio_q;
    return r;
  endfunction

  function automatic bo_event_t random_event(run_kind_e what);
    bo_event_t   ev;
    int unsigned pick;
    pick         = $urandom_range(0, 99);
    ev.kind      = KIND_ACK;
    ev.retry     = 1'($urandom_range(0, 1));
    ev.last_frag = 1'b1;
    ev.rslot     = 16'($urandom_range(0, 65535));
    ev.rfrac     = 16'($urandom_range(0, 65535));
    case (what)
      RUN_ACK: ev.last_frag = (pick >= 10);
      RUN_FAIL: begin
        ev.retry = 1'b1;
        if (pick < 75) ev.kind = KIND_MISS_ACK;
        else if (pick < 88) ev.kind = KIND_MISS_CTS;
        else ev.kind = KIND_COLLISION;
      end
      default: begin
        if (pick < 50) begin
          ev.kind      = KIND_W'($urandom_range(0, 7));
          ev.last_frag = 1'($urandom_range(0, 1));
        end else if (pick < 70) begin
          ev.kind  = KIND_MISS_ACK;
          ev.retry = 1'b0;
        end else if (pick < 85) begin
          ev.kind = KIND_NOACK_END;
        end else begin
          ev.kind  = KIND_MISS_CTS;
          ev.retry = 1'b0;
        end
      end
    endcase
    return ev;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("result %0d %s: got 0x%0h, expected 0x%0h", results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CW_MIN: cfg_q.cw_min = val[CW_W-1:0];
      REG_CW_MAX: cfg_q.cw_max = val[CW_W-1:0];
      REG_ALPHA:  cfg_q.alpha  = val[Q_W-1:0];
      REG_PSI:    cfg_q.psi    = val[PSI_W-1:0];
      REG_PHI:    cfg_q.phi    = val[Q_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_item(input bo_event_t ev, input logic use_typed, input sdb_res_t typed);
    logic [IN_TDATA_W-1:0] word;
    sdb_res_t              predicted;
    word       = '0;
    word[32:0] = {ev.rfrac, ev.rslot, ev.retry};
    if (idle_on && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= ev.kind;
    s_axis_tlast  <= ev.last_frag;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = predict_backoff(ev);
    expected_backoffs.push_back(use_typed ? typed : predicted);
    if (ev.kind <= KIND_NOACK_END && !(ev.kind == KIND_ACK && !ev.last_frag)) work_items++;
  endtask

  always @(posedge clk_i) begin : result_check
    sdb_res_t got;
    sdb_res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.backoff_valid = m_axis_tdata[0];
        got.backoff_slots = m_axis_tdata[20:1];
        got.deterministic = m_axis_tuser;
        got.window_now    = m_axis_tdata[30:21];
        got.failures_now  = m_axis_tdata[34:31];
        got.ratio_now     = m_axis_tdata[50:35];
        results_seen++;
        if (expected_backoffs.size() == 0) begin
          report_mismatch("result with none pending, backoff_slots", got.backoff_slots, 0);
        end else begin
          want = expected_backoffs.pop_front();
          if (got.backoff_valid !== want.backoff_valid)
            report_mismatch("backoff_valid", got.backoff_valid, want.backoff_valid);
          if (got.backoff_slots !== want.backoff_slots)
            report_mismatch("backoff_slots", got.backoff_slots, want.backoff_slots);
          if (got.deterministic !== want.deterministic)
            report_mismatch("deterministic", got.deterministic, want.deterministic);
          if (got.window_now !== want.window_now)
            report_mismatch("window_now", got.window_now, want.window_now);
          if (got.failures_now !== want.failures_now)
            report_mismatch("failures_now", got.failures_now, want.failures_now);
          if (got.ratio_now !== want.ratio_now)
            report_mismatch("ratio_now", got.ratio_now, want.ratio_now);
          if (m_axis_tdata[OUT_TDATA_W-1:51] !== '0)
            report_mismatch("tdata fill", m_axis_tdata[OUT_TDATA_W-1:51], 0);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 10);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("semi_deterministic_backoff_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n;
    int          ph;
    int unsigned goal;
    sdb_cfg_t    setup;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    s_axis_tlast  <= 1'b0;
    m_axis_tready <= 1'b0;
    rst_ni        <= 1'b0;
    cfg_q         = '{CW_MIN_RST, CW_MAX_RST, ALPHA_RST, PSI_RST, PHI_RST};
    win_q         = CW_MIN_RST;
    fails_q       = '0;
    ratio_q       = '0;
    mismatches    = 0;
    results_seen  = 0;
    work_items    = 0;
    quiet_cycles  = 0;
    stall_left    = 0;
    idle_on       = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[i]) begin
      repeat (directed_plan[i].reps)
        send_item(directed_plan[i].ev, directed_plan[i].typed, directed_plan[i].want);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      s_axis_tvalid <= 1'b0;
      while (expected_backoffs.size() != 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);
      case (ph)
        0: setup = '{CW_MIN_RST, CW_MAX_RST, ALPHA_RST, PSI_RST, PHI_RST};
        1: setup = '{10'd1023, 10'd1023, 16'hFFFF, 4'd1, 16'hFFFF};
        2: setup = '{10'd1, 10'd1023, 16'h0000, 4'd15, 16'h0000};
        3: setup = '{10'd0, 10'd0, 16'h8000, 4'd0, 16'd40000};
        4: setup = '{10'd63, 10'd7, 16'hFFFF, 4'd2, 16'hFFFF};
        default: setup = '{CW_W'($urandom_range(0, 1023)), CW_W'($urandom_range(0, 1023)),
                           Q_W'($urandom_range(0, 65535)), PSI_W'($urandom_range(0, 15)),
                           Q_W'($urandom_range(0, 65535))};
      endcase
      write_reg(REG_CW_MIN, 32'(setup.cw_min));
      write_reg(REG_CW_MAX, 32'(setup.cw_max));
      write_reg(REG_ALPHA, 32'(setup.alpha));
      write_reg(REG_PSI, 32'(setup.psi));
      write_reg(REG_PHI, 32'(setup.phi));
      goal = work_items + PHASE_ITEMS;
      while (work_items < goal) begin
        idle_on = (ph != PHASES - 1) && ($urandom_range(0, 4) != 0);
        n = $urandom_range(1, 6);
        repeat (n) send_item(random_event(RUN_ACK), 1'b0, NO_WANT);
        n = $urandom_range(1, 8);
        repeat (n) send_item(random_event(RUN_FAIL), 1'b0, NO_WANT);
        if ($urandom_range(0, 2) == 0) send_item(random_event(RUN_NOISE), 1'b0, NO_WANT);
      end
    end

    s_axis_tvalid <= 1'b0;
    idle_on = 1'b0;
    while (expected_backoffs.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0)
      $display("semi_deterministic_backoff_top regression: pass");
    else
      $display("semi_deterministic_backoff_top regression: fail");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/sdb_pkg.sv
design/sdb_seq.sv
design/sdb_dp.sv
design/semi_deterministic_backoff_top.sv
sim/tb_top.sv
